FILE: src/lsakc_pkg.sv
// ----------------------------------------------------------------------------
// lsakc_pkg: shared types and constants of the LRU key cache
// Beat layouts, field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package lsakc_pkg;

  localparam int unsigned KEY_IN_W    = 32;
  localparam int unsigned CFG_W       = 9;
  localparam int unsigned SET_OUT_W   = 8;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned KEYS_HELD_W = 11;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 152;

  localparam logic [CFG_W-1:0] NUM_SETS_RST = 9'd256;

  // Largest divisor the 9-bit register can ask for.
  localparam int unsigned CFG_MAX = 511;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_CMP
  } state_e;

  // Result beat, lowest field last.
  typedef struct packed {
    logic [1:0]             pad;
    logic [KEYS_HELD_W-1:0] keys_held;
    logic [TOTAL_W-1:0]     writeback_total;
    logic [TOTAL_W-1:0]     miss_total;
    logic [TOTAL_W-1:0]     hit_total;
    logic [KEY_IN_W-1:0]    writeback_key;
    logic                   writeback_valid;
    logic                   fetch_request;
    logic [SET_OUT_W-1:0]   set_index;
    logic                   hit;
  } out_beat_t;

  typedef struct packed {
    logic [6:0]          pad;
    logic                mark_dirty;
    logic [KEY_IN_W-1:0] lookup_key;
  } in_beat_t;

endpackage

FILE: src/lsakc_ram.sv
// ----------------------------------------------------------------------------
// lsakc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module lsakc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/lru_set_assoc_key_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_set_assoc_key_cache_unit: set-associative LRU key cache, write-back
// Looks up one key per beat, keeps per-set LRU order, reports hit/miss,
// eviction write-backs and running totals.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis   : one lookup per beat, tdata = {mark_dirty, lookup_key}.
//   m_axis   : exactly one result beat per lookup, in order.
//   cfg      : cfg_we_i/cfg_wdata_i write num_sets (0 acts as 1, values above
//              SETS act as SETS). Write only while the cache is idle.
// Timing:
//   A lookup shifts min(KEY_BITS,32) key bits through the restoring
//   remainder unit (one quotient bit a cycle) to form key mod num_sets, then
//   reads the set and does the compare/update; a new beat is accepted only
//   once the previous lookup has left its update state. The result
//   is registered and appears the edge after the update.
// Reset:
//   After rst_ni is released the tag-state RAM is swept, one set per cycle,
//   through all SETS sets; s_axis_tready stays low meanwhile. Key RAM is not
//   cleared: it is only read under a valid bit.
// Stall:
//   The result sits in the output register until taken. The next lookup is
//   still accepted and computed; it waits in its update cycle, without
//   touching the RAMs, until the output register frees up.
// ----------------------------------------------------------------------------
module lru_set_assoc_key_cache_unit #(
  parameter int unsigned SETS     = 256,
  parameter int unsigned WAYS     = 4,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config: num_sets [8:0]
  input  logic                                cfg_we_i,
  input  logic [lsakc_pkg::CFG_W-1:0]         cfg_wdata_i,
  // lookup_key [31:0], mark_dirty [32], zero [39:33]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lsakc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // hit [0], set_index [8:1], fetch_request [9], writeback_valid [10],
  // writeback_key [42:11], hit_total [74:43], miss_total [106:75],
  // writeback_total [138:107], keys_held [149:139], zero [151:150]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lsakc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  import lsakc_pkg::*;

  // Stored key width: the input carries 32 bits, KEY_BITS may trim it.
  localparam int unsigned KW   = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int unsigned CW   = $clog2(KW);
  localparam int unsigned SIW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned RW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WIW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SCAP = (SETS > CFG_MAX) ? CFG_MAX : SETS;
  localparam logic [RW-1:0] RANK_LRU = RW'(WAYS - 1);

  typedef struct packed {
    logic [WAYS-1:0][RW-1:0] rank;
    logic [WAYS-1:0]         dirty;
    logic [WAYS-1:0]         valid;
  } meta_t;

  typedef logic [WAYS-1:0][KW-1:0] key_row_t;

  localparam int unsigned META_W = $bits(meta_t);
  localparam int unsigned KROW_W = $bits(key_row_t);

  // ---------------------------------------------------------------- state
  state_e                 state_q, state_d;
  logic [SIW-1:0]         clr_q, clr_d;
  logic [CFG_W-1:0]       num_sets_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [KW-1:0]          key_q, key_d;      // key under lookup
  logic [KW-1:0]          shf_q, shf_d;      // dividend, MSB first
  logic                   mark_q, mark_d;
  logic [CFG_W-1:0]       div_q, div_d;
  logic [CFG_W-1:0]       rem_q, rem_d;
  logic [TOTAL_W-1:0]     hit_cnt_q, hit_cnt_d;
  logic [TOTAL_W-1:0]     miss_cnt_q, miss_cnt_d;
  logic [TOTAL_W-1:0]     wb_cnt_q, wb_cnt_d;
  logic [KEYS_HELD_W-1:0] held_q, held_d;
  logic                   out_valid_q, out_valid_d;
  out_beat_t              out_q, out_d;

  in_beat_t               in_beat;
  logic                   in_fire;
  logic                   out_free;
  logic                   adv;
  logic [CFG_W-1:0]       eff_sets;
  logic [CFG_W:0]         rem_try;
  logic [SIW-1:0]         set_idx;

  // ------------------------------------------------------------- RAM side
  logic                   meta_we;
  logic [SIW-1:0]         meta_waddr;
  meta_t                  meta_wdata, meta_rd, meta_nx;
  logic                   key_we;
  key_row_t               keys_rd, keys_nx;

  // ----------------------------------------------------------- set update
  logic [WAYS-1:0]        hit_vec;
  logic                   found, full, wb;
  logic [WIW-1:0]         hit_way, free_way, vic_way, slot;
  logic [RW-1:0]          hit_rank;

  assign in_beat  = in_beat_t'(s_axis_tdata);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign adv      = (state_q == ST_CMP) && out_free;
  assign set_idx  = SIW'(rem_q);
  assign rem_try  = {rem_q, shf_q[KW-1]};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Effective set count: 0 acts as 1, clamp at SETS.
  always_comb begin
    if (num_sets_q == '0) begin
      eff_sets = CFG_W'(1);
    end else if (num_sets_q > CFG_W'(SCAP)) begin
      eff_sets = CFG_W'(SCAP);
    end else begin
      eff_sets = num_sets_q;
    end
  end

  lsakc_ram #(
    .WIDTH (META_W),
    .DEPTH (SETS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (set_idx),
    .rdata_o (meta_rd)
  );

  lsakc_ram #(
    .WIDTH (KROW_W),
    .DEPTH (SETS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (set_idx),
    .wdata_i (keys_nx),
    .raddr_i (set_idx),
    .rdata_o (keys_rd)
  );

  assign meta_we    = (state_q == ST_CLEAR) || adv;
  assign meta_waddr = (state_q == ST_CLEAR) ? clr_q : set_idx;
  assign meta_wdata = (state_q == ST_CLEAR) ? meta_t'('0) : meta_nx;
  assign key_we     = adv && !found;

  // Tag compare, free-way and victim pick, and the new row.
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    vic_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = meta_rd.valid[w] && (keys_rd[w] == key_q);
      if (hit_vec[w]) begin
        hit_way = WIW'(w);
      end
      if (!meta_rd.valid[w]) begin
        free_way = WIW'(w);
      end
    end
    // In a full set the ranks are a permutation; LRU holds the top rank.
    for (int w = 0; w < WAYS; w++) begin
      if (meta_rd.rank[w] == RANK_LRU) begin
        vic_way = WIW'(w);
      end
    end
    found    = |hit_vec;
    full     = &meta_rd.valid;
    hit_rank = meta_rd.rank[hit_way];
    slot     = found ? hit_way : (full ? vic_way : free_way);
    wb       = !found && full && meta_rd.dirty[vic_way];

    meta_nx = meta_rd;
    keys_nx = keys_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (found) begin
        if (meta_rd.valid[w] && (meta_rd.rank[w] < hit_rank)) begin
          meta_nx.rank[w] = meta_rd.rank[w] + RW'(1);
        end
      end else if (meta_rd.valid[w] && !(full && (WIW'(w) == slot))) begin
        meta_nx.rank[w] = meta_rd.rank[w] + RW'(1);
      end
    end
    meta_nx.rank[slot] = '0;
    if (found) begin
      meta_nx.dirty[slot] = meta_rd.dirty[slot] | mark_q;
    end else begin
      meta_nx.valid[slot] = 1'b1;
      meta_nx.dirty[slot] = mark_q;
      keys_nx[slot]       = key_q;
    end
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    shf_d       = shf_q;
    mark_d      = mark_q;
    div_d       = div_q;
    rem_d       = rem_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    wb_cnt_d    = wb_cnt_q;
    held_d      = held_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SIW'(1);
        if (clr_q == SIW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          key_d   = in_beat.lookup_key[KW-1:0];
          shf_d   = in_beat.lookup_key[KW-1:0];
          mark_d  = in_beat.mark_dirty;
          div_d   = eff_sets;
          rem_d   = '0;
          cnt_d   = CW'(KW - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // Restoring remainder, one dividend bit per cycle.
        if (rem_try >= {1'b0, div_q}) begin
          rem_d = CFG_W'(rem_try - {1'b0, div_q});
        end else begin
          rem_d = CFG_W'(rem_try);
        end
        shf_d = {shf_q[KW-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (out_free) begin
          if (found) begin
            hit_cnt_d = hit_cnt_q + TOTAL_W'(1);
          end else begin
            miss_cnt_d = miss_cnt_q + TOTAL_W'(1);
            if (!full) begin
              held_d = held_q + KEYS_HELD_W'(1);
            end
          end
          if (wb) begin
            wb_cnt_d = wb_cnt_q + TOTAL_W'(1);
          end
          out_d.pad             = '0;
          out_d.hit             = found;
          out_d.set_index       = SET_OUT_W'(rem_q);
          out_d.fetch_request   = !found;
          out_d.writeback_valid = wb;
          out_d.writeback_key   = wb ? KEY_IN_W'(keys_rd[vic_way]) : '0;
          out_d.hit_total       = hit_cnt_d;
          out_d.miss_total      = miss_cnt_d;
          out_d.writeback_total = wb_cnt_d;
          out_d.keys_held       = held_d;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      num_sets_q  <= NUM_SETS_RST;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      wb_cnt_q    <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      wb_cnt_q    <= wb_cnt_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        num_sets_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    shf_q  <= shf_d;
    mark_q <= mark_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  // ------------------------------------------------------------ assertions
  a_rise_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_CMP))
    else $error("result beat raised outside the update cycle");

  a_fetch_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.fetch_request == !out_q.hit))
    else $error("fetch_request disagrees with hit");

  a_wb_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.writeback_valid |-> !out_q.hit)
    else $error("write-back reported on a hit");

  a_wb_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_q.writeback_valid |-> (out_q.writeback_key == '0))
    else $error("write-back key not zero without a write-back");

  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_DIV) && (cnt_q == CW'(KW - 1)))
    else $error("accepted lookup did not start the remainder unit");

endmodule
